// ===== sv/apw_pkg.sv =====
// ----------------------------------------------------------------------------
// Action potential waveform package
// Shared widths, constants, region codes and the sideband record that
// travels with each item down the pipeline.
// ----------------------------------------------------------------------------
package apw_pkg;

  localparam int WB = 28;
  localparam logic [28:0] W_ONE = 29'h1000_0000;
  localparam logic [26:0] E_INV = 27'd98751886;

  localparam int REM_W = 39;
  localparam int DVS_W = 38;
  localparam int QUO_W = 33;

  localparam int DIV_CELLS = 33;
  localparam int EXP_TERMS = 12;
  localparam int EXP_STAGES = 3;
  localparam int POW_CELLS = 19;
  localparam int SB_LEN = EXP_TERMS * EXP_STAGES + POW_CELLS;
  localparam int POST_STAGES = 5;
  localparam int NST = 1 + DIV_CELLS + 1 + SB_LEN + POST_STAGES + 1;

  function automatic logic [28:0] einv_pow(input int n);
    logic [55:0] p;
    logic [28:0] r;
    r = W_ONE;
    for (int i = 0; i < n; i++) begin
      p = r * E_INV;
      r = {1'b0, p[55:28]};
    end
    return r;
  endfunction

  localparam logic [28:0] E4 = einv_pow(4);
  localparam logic [29:0] D2 = 30'({W_ONE - E4, 2'b00});
  localparam logic [28:0] M2 = 29'((64'd1 << 58) / 64'(D2));

  typedef enum logic [1:0] {
    RGN_EARLY,
    RGN_MID,
    RGN_LATE
  } region_t;

  typedef struct packed {
    logic               bad;
    region_t            region;
    logic               one;
    logic [4:0]         n;
    logic [28:0]        w;
    logic signed [31:0] rest;
    logic signed [31:0] peak;
  } side_t;

endpackage

// ===== sv/action_potential_waveform.sv =====
// ----------------------------------------------------------------------------
// Action potential waveform
// Returns one cell's action potential from its timing and potential levels.
// ----------------------------------------------------------------------------
// An item carries the evaluation time and the cell's rest level, peak level,
// depolarization and repolarization times. It is taken on a transfer with
// item_valid and item_ready both high. Each item gives one result (potential,
// bad_timing), offered on result_valid until a transfer with result_ready.
// The block takes one item per cycle while the output is not held. It has 96
// register stages: the front stage, the ratio divider (33 cells, one quotient
// bit each), the exponent argument stage, the series for e^-f (12 cells of
// three stages), the integer exponent chain (19 cells) and a six-stage tail.
// All stages advance together: while a result waits and result_ready is low,
// the pipeline holds and item_ready is low unless the output stage is empty.
// Reset clears every stage's valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
module action_potential_waveform (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic signed [31:0] time_now,
  input  logic signed [31:0] rest_level,
  input  logic signed [31:0] peak_level,
  input  logic signed [31:0] depol_at,
  input  logic signed [31:0] repol_at,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] potential,
  output logic               bad_timing
);

  localparam int NC = apw_pkg::DIV_CELLS;
  localparam int HS = apw_pkg::EXP_TERMS * apw_pkg::EXP_STAGES;
  localparam int SL = apw_pkg::SB_LEN;

  logic                  en;
  logic [apw_pkg::NST-1:0] vld;

  assign en = !vld[apw_pkg::NST-1] || result_ready;
  assign item_ready = en;
  assign result_valid = vld[apw_pkg::NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[apw_pkg::NST-2:0], item_valid};
    end
  end

  // Front stage: region decode and divider operands.
  logic signed [32:0] d, dmt, tmd, tmr;
  logic [37:0]        a_e;
  logic [36:0]        num_l;
  logic               bad_c, early_c, mid_c, one_e, one_l;
  apw_pkg::side_t     side_c;
  logic [apw_pkg::REM_W-1:0] num_c;
  logic [33:0]        den_c;

  always_comb begin
    d = 33'(repol_at) - 33'(depol_at);
    dmt = 33'(depol_at) - 33'(time_now);
    tmd = 33'(time_now) - 33'(depol_at);
    tmr = 33'(time_now) - 33'(repol_at);
    bad_c = d[32] || (d == 33'sd0);
    early_c = dmt > 33'sd0;
    mid_c = !early_c && (tmr <= 33'sd0);
    a_e = {1'b0, dmt, 4'b0} + {2'b0, dmt, 3'b0} + {5'b0, dmt};
    one_e = a_e > {3'b0, d, 1'b0};
    one_l = {1'b0, tmr} >= {d, 1'b0};
    num_l = {1'b0, tmr, 3'b0} + {3'b0, tmr, 1'b0};
    side_c = '0;
    side_c.bad = bad_c;
    side_c.rest = rest_level;
    side_c.peak = peak_level;
    if (early_c) begin
      side_c.region = apw_pkg::RGN_EARLY;
      side_c.one = one_e;
      num_c = one_e ? '0 : {1'b0, a_e};
      den_c = {d, 1'b0};
    end else if (mid_c) begin
      side_c.region = apw_pkg::RGN_MID;
      side_c.one = 1'b0;
      num_c = {6'b0, tmd};
      den_c = {1'b0, d};
    end else begin
      side_c.region = apw_pkg::RGN_LATE;
      side_c.one = one_l;
      num_c = one_l ? '0 : {2'b0, num_l};
      den_c = {1'b0, d};
    end
  end

  logic [apw_pkg::REM_W-1:0] rem_c [0:NC];
  logic [apw_pkg::DVS_W-1:0] dvs_c [0:NC];
  logic [apw_pkg::QUO_W-1:0] quo_c [0:NC];
  logic [apw_pkg::REM_W-1:0] rem_f;
  logic [apw_pkg::DVS_W-1:0] dvs_f;
  apw_pkg::side_t            sa [0:NC];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_f <= num_c;
      dvs_f <= {den_c, 4'b0};
      sa[0] <= side_c;
      for (int i = 1; i <= NC; i++) begin
        sa[i] <= sa[i-1];
      end
    end
  end

  assign rem_c[0] = rem_f;
  assign dvs_c[0] = dvs_f;
  assign quo_c[0] = '0;

  for (genvar i = 0; i < NC; i++) begin : g_div
    apw_div_cell u_div (
      .clk     (clk),
      .en      (en),
      .rem_in  (rem_c[i]),
      .dvs_in  (dvs_c[i]),
      .quo_in  (quo_c[i]),
      .rem_out (rem_c[i+1]),
      .dvs_out (dvs_c[i+1]),
      .quo_out (quo_c[i+1])
    );
  end

  // Exponent argument stage.
  logic [32:0]    z_c, q_d;
  logic [27:0]    fx;
  apw_pkg::side_t sx_c;
  apw_pkg::side_t sb [0:SL];

  always_comb begin
    q_d = quo_c[NC];
    sx_c = sa[NC];
    unique case (sa[NC].region)
      apw_pkg::RGN_MID:  z_c = 33'({apw_pkg::W_ONE - q_d[28:0], 2'b00});
      apw_pkg::RGN_LATE: z_c = q_d;
      default:           z_c = '0;
    endcase
    sx_c.n = z_c[32:28];
    sx_c.w = sa[NC].one ? apw_pkg::W_ONE : q_d[28:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx <= z_c[27:0];
      sb[0] <= sx_c;
      for (int i = 1; i <= SL; i++) begin
        sb[i] <= sb[i-1];
      end
    end
  end

  logic [27:0] hf [0:apw_pkg::EXP_TERMS];
  logic [28:0] hr [0:apw_pkg::EXP_TERMS];
  logic [28:0] pr [0:apw_pkg::POW_CELLS];

  assign hf[0] = fx;
  assign hr[0] = apw_pkg::W_ONE;

  for (genvar h = 0; h < apw_pkg::EXP_TERMS; h++) begin : g_exp
    apw_exp_cell #(.K(apw_pkg::EXP_TERMS - h)) u_exp (
      .clk   (clk),
      .en    (en),
      .f_in  (hf[h]),
      .r_in  (hr[h]),
      .f_out (hf[h+1]),
      .r_out (hr[h+1])
    );
  end

  assign pr[0] = hr[apw_pkg::EXP_TERMS];

  for (genvar p = 0; p < apw_pkg::POW_CELLS; p++) begin : g_pow
    apw_pow_cell #(.IDX(p)) u_pow (
      .clk   (clk),
      .en    (en),
      .cnt   (sb[HS+p].n),
      .r_in  (pr[p]),
      .r_out (pr[p+1])
    );
  end

  // Weight and output stages.
  logic [28:0]        e_c, diff_c;
  logic [29:0]        p1_num2, p2_num2;
  logic [28:0]        p1_e, p2_e, p3_e;
  logic [58:0]        p2_p;
  logic [28:0]        p3_q2, q2_c, wm_c;
  logic [31:0]        p3_rem;
  logic [59:0]        rem_full;
  logic [28:0]        w_c, p4_w;
  logic signed [32:0] p4_span;
  logic signed [62:0] mul_c, p5_prod;
  logic signed [34:0] sc_c;
  logic signed [35:0] res_c;
  apw_pkg::side_t     p1_s, p2_s, p3_s, p4_s, p5_s;

  always_comb begin
    e_c = pr[apw_pkg::POW_CELLS];
    diff_c = (e_c > apw_pkg::E4) ? e_c - apw_pkg::E4 : '0;
    q2_c = p2_p[58:30];
    rem_full = {2'b0, p2_num2, 28'b0} - 60'(q2_c) * 60'(apw_pkg::D2);
    wm_c = (p3_rem >= 32'(apw_pkg::D2)) ? p3_q2 + 29'd1 : p3_q2;
    unique case (p3_s.region)
      apw_pkg::RGN_MID:  w_c = wm_c;
      apw_pkg::RGN_LATE: w_c = p3_s.one ? apw_pkg::W_ONE : apw_pkg::W_ONE - (p3_e >> 2);
      default:           w_c = p3_s.w;
    endcase
    mul_c = p4_span * $signed({1'b0, p4_w});
    sc_c = p5_prod[62:28];
    res_c = 36'(p5_s.peak) - 36'(sc_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_num2 <= 30'({diff_c, 1'b0}) + 30'(diff_c);
      p1_e <= e_c;
      p1_s <= sb[SL];
      p2_p <= p1_num2 * apw_pkg::M2;
      p2_num2 <= p1_num2;
      p2_e <= p1_e;
      p2_s <= p1_s;
      p3_q2 <= q2_c;
      p3_rem <= rem_full[31:0];
      p3_e <= p2_e;
      p3_s <= p2_s;
      p4_w <= w_c;
      p4_span <= 33'(p3_s.peak) - 33'(p3_s.rest);
      p4_s <= p3_s;
      p5_prod <= mul_c + 63'sd134217728;
      p5_s <= p4_s;
      bad_timing <= p5_s.bad;
      if (p5_s.bad) begin
        potential <= p5_s.rest;
      end else if (res_c[35:31] != {5{res_c[35]}}) begin
        potential <= res_c[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        potential <= res_c[31:0];
      end
    end
  end

endmodule

// ===== sv/apw_div_cell.sv =====
// ----------------------------------------------------------------------------
// Restoring divider cell
// Produces one quotient bit per cycle while en is high and hands the partial remainder on.
// ----------------------------------------------------------------------------
module apw_div_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [apw_pkg::REM_W-1:0]     rem_in,
  input  logic [apw_pkg::DVS_W-1:0]     dvs_in,
  input  logic [apw_pkg::QUO_W-1:0]     quo_in,
  output logic [apw_pkg::REM_W-1:0]     rem_out,
  output logic [apw_pkg::DVS_W-1:0]     dvs_out,
  output logic [apw_pkg::QUO_W-1:0]     quo_out
);

  logic                        ge;
  logic [apw_pkg::REM_W-1:0]   diff;

  always_comb begin
    ge = rem_in >= {1'b0, dvs_in};
    diff = ge ? rem_in - {1'b0, dvs_in} : rem_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= {diff[apw_pkg::REM_W-2:0], 1'b0};
      dvs_out <= dvs_in;
      quo_out <= {quo_in[apw_pkg::QUO_W-2:0], ge};
    end
  end

endmodule

// ===== sv/apw_exp_cell.sv =====
// ----------------------------------------------------------------------------
// Exponential series cell
// One Horner step of the series for e^-f: r = 1 - floor(floor(f*r) / K).
// ----------------------------------------------------------------------------
module apw_exp_cell #(
  parameter int K = 1
) (
  input  logic        clk,
  input  logic        en,
  input  logic [27:0] f_in,
  input  logic [28:0] r_in,
  output logic [27:0] f_out,
  output logic [28:0] r_out
);

  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);

  logic [56:0] prod;
  logic [27:0] x1, f1;
  logic [60:0] rp;
  logic [27:0] qe2, x2, f2;
  logic [32:0] back, rm;
  logic [27:0] qc;

  assign prod = f_in * r_in;
  assign rp = x1 * RECIP;

  always_comb begin
    back = 33'(qe2) * 33'(K);
    rm = 33'(x2) - back;
    qc = (rm >= 33'(K)) ? qe2 + 28'd1 : qe2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= prod[55:28];
      f1 <= f_in;
      qe2 <= rp[59:32];
      x2 <= x1;
      f2 <= f1;
      r_out <= apw_pkg::W_ONE - {1'b0, qc};
      f_out <= f2;
    end
  end

endmodule

// ===== sv/apw_pow_cell.sv =====
// ----------------------------------------------------------------------------
// Integer exponent cell
// Multiplies by e^-1 when the integer part of the exponent exceeds IDX.
// ----------------------------------------------------------------------------
module apw_pow_cell #(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [4:0]  cnt,
  input  logic [28:0] r_in,
  output logic [28:0] r_out
);

  logic [55:0] p;

  assign p = r_in * apw_pkg::E_INV;

  always_ff @(posedge clk) begin
    if (en) begin
      r_out <= (cnt > 5'(IDX)) ? {1'b0, p[55:28]} : r_in;
    end
  end

endmodule

// ===== sim/action_potential_waveform_check.sv =====
// ----------------------------------------------------------------------------
// Action potential waveform checker
// Watches the item and result channels of the block. It predicts the result
// of every item transfer and compares each result transfer, in order,
// against the oldest waiting prediction.
// ----------------------------------------------------------------------------
module action_potential_waveform_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  logic signed [31:0] time_now,
  input  logic signed [31:0] rest_level,
  input  logic signed [31:0] peak_level,
  input  logic signed [31:0] depol_at,
  input  logic signed [31:0] repol_at,
  input  logic               result_valid,
  input  logic               result_ready,
  input  logic signed [31:0] potential,
  input  logic               bad_timing,
  output int                 mismatches,
  output int                 pending
);

  localparam int QB = 28;
  localparam longint unsigned Q_ONE = 64'd1 << QB;
  localparam longint unsigned Q_MASK = Q_ONE - 64'd1;
  localparam longint unsigned EXP_M1 = 64'd98751886;

  typedef struct packed {
    logic signed [31:0] potential;
    logic               bad_timing;
  } outcome_t;

  outcome_t waiting_outcomes[$];

  function automatic longint unsigned frac_ratio(longint unsigned num,
                                                 longint unsigned den);
    return ((num / den) << QB) + (((num % den) << QB) / den);
  endfunction

  function automatic longint unsigned decay(longint unsigned z);
    longint unsigned n;
    longint unsigned f;
    longint unsigned r;
    n = z >> QB;
    f = z & Q_MASK;
    if (n >= 20) begin
      return 0;
    end
    r = Q_ONE;
    for (int k = 12; k >= 1; k--) begin
      r = Q_ONE - ((f * r) >> QB) / longint'(k);
    end
    for (longint unsigned i = 0; i < n; i++) begin
      r = (r * EXP_M1) >> QB;
    end
    return r;
  endfunction

  function automatic outcome_t cell_potential(logic signed [31:0] t32,
                                              logic signed [31:0] rest32,
                                              logic signed [31:0] peak32,
                                              logic signed [31:0] dep32,
                                              logic signed [31:0] rep32);
    outcome_t o;
    longint t;
    longint rest;
    longint peak;
    longint dep;
    longint rep;
    longint d;
    longint span;
    longint prod;
    longint res;
    longint unsigned w;
    longint unsigned a;
    longint unsigned b;
    longint unsigned e;
    longint unsigned e4;
    longint unsigned diff;
    longint unsigned late;
    t = t32;
    rest = rest32;
    peak = peak32;
    dep = dep32;
    rep = rep32;
    d = rep - dep;
    if (d <= 0) begin
      o.potential = rest32;
      o.bad_timing = 1'b1;
      return o;
    end
    if (t < dep) begin
      a = 25 * (dep - t);
      b = 2 * d;
      w = (a > b) ? Q_ONE : frac_ratio(a, b);
    end else if (t <= rep) begin
      e = decay(4 * (Q_ONE - frac_ratio(t - dep, d)));
      e4 = decay(4 * Q_ONE);
      diff = (e > e4) ? (e - e4) : 0;
      w = ((3 * diff) << QB) / (4 * (Q_ONE - e4));
    end else begin
      late = t - rep;
      if (late >= 2 * d) begin
        w = Q_ONE;
      end else begin
        w = Q_ONE - (decay(frac_ratio(10 * late, d)) >> 2);
      end
    end
    span = peak - rest;
    prod = span * longint'(w) + (longint'(1) << (QB - 1));
    res = peak - (prod >>> QB);
    if (res > 64'sd2147483647) begin
      res = 64'sd2147483647;
    end
    if (res < -64'sd2147483648) begin
      res = -64'sd2147483648;
    end
    o.potential = res[31:0];
    o.bad_timing = 1'b0;
    return o;
  endfunction

  assign pending = waiting_outcomes.size();

  always @(posedge clk) begin
    outcome_t exp_o;
    if (rst) begin
      mismatches <= 0;
    end
    if (!rst && item_valid && item_ready) begin
      waiting_outcomes = {waiting_outcomes,
                          cell_potential(time_now, rest_level, peak_level,
                                         depol_at, repol_at)};
    end
    if (!rst && result_valid && result_ready) begin
      if (waiting_outcomes.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) begin
          $display("unexpected result transfer: potential %0d bad_timing %0b",
                   potential, bad_timing);
        end
      end else begin
        exp_o = waiting_outcomes.pop_front();
        if (exp_o.potential !== potential || exp_o.bad_timing !== bad_timing) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("mismatch: expected potential %0d bad_timing %0b, got %0d %0b",
                     exp_o.potential, exp_o.bad_timing, potential, bad_timing);
          end
        end
      end
    end
  end

endmodule

// ===== sim/action_potential_waveform_test.sv =====
// ----------------------------------------------------------------------------
// Action potential waveform testbench
// Drives directed corner cases and then random cell timings through the
// block with random gaps on both channels, except in steady spans; a checker predicts and compares.
// ----------------------------------------------------------------------------
module action_potential_waveform_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1900;
  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] UNIT = 32'sh0001_0000;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  logic signed [31:0] time_now;
  logic signed [31:0] rest_level;
  logic signed [31:0] peak_level;
  logic signed [31:0] depol_at;
  logic signed [31:0] repol_at;
  logic               result_valid;
  logic               result_ready;
  logic signed [31:0] potential;
  logic               bad_timing;
  int                 mismatches;
  int                 pending;
  int                 cycles;
  bit                 steady;

  action_potential_waveform u_dut (.*);

  action_potential_waveform_check u_check (.*);

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return S_MAX;
    end
    if (v < -64'sd2147483648) begin
      return S_MIN;
    end
    return v[31:0];
  endfunction

  task automatic send_cell(logic signed [31:0] t, logic signed [31:0] rest,
                           logic signed [31:0] peak, logic signed [31:0] dep,
                           logic signed [31:0] rep);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    time_now = t;
    rest_level = rest;
    peak_level = peak;
    depol_at = dep;
    repol_at = rep;
    do begin
      @(posedge clk);
    end while (!item_ready);
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  initial begin
    int stall;
    result_ready = 1'b0;
    @(negedge clk);
    while (rst) begin
      @(negedge clk);
    end
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      result_ready = 1'b0;
      repeat (stall) @(negedge clk);
      result_ready = 1'b1;
      do begin
        @(posedge clk);
      end while (!result_valid);
      @(negedge clk);
    end
  end

  initial begin
    longint dep;
    longint d;
    longint t;
    int sel;
    int scale;
    logic signed [31:0] rest;
    logic signed [31:0] peak;
    rst = 1'b1;
    steady = 1'b0;
    item_valid = 1'b0;
    time_now = '0;
    rest_level = '0;
    peak_level = '0;
    depol_at = '0;
    repol_at = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_cell(0, 5 * UNIT, 40 * UNIT, 10 * UNIT, 10 * UNIT);
    send_cell(S_MAX, S_MIN, S_MAX, S_MAX, S_MIN);
    send_cell(-3 * UNIT, S_MAX, S_MIN, 7 * UNIT, 6 * UNIT);
    send_cell(50 * UNIT, S_MIN, S_MAX, 0, 100 * UNIT);
    send_cell(50 * UNIT, S_MAX, S_MIN, 0, 100 * UNIT);
    send_cell(S_MIN, -80 * UNIT, 20 * UNIT, 0, 100 * UNIT);
    send_cell(-8 * UNIT, -80 * UNIT, 20 * UNIT, 0, 100 * UNIT);
    send_cell(-8 * UNIT - 1, -80 * UNIT, 20 * UNIT, 0, 100 * UNIT);
    send_cell(-4 * UNIT, -80 * UNIT, 20 * UNIT, 0, 100 * UNIT);
    send_cell(0, -80 * UNIT, 20 * UNIT, 0, 100 * UNIT);
    send_cell(100 * UNIT, -80 * UNIT, 20 * UNIT, 0, 100 * UNIT);
    send_cell(100 * UNIT + 1, -80 * UNIT, 20 * UNIT, 0, 100 * UNIT);
    send_cell(300 * UNIT - 1, -80 * UNIT, 20 * UNIT, 0, 100 * UNIT);
    send_cell(300 * UNIT, -80 * UNIT, 20 * UNIT, 0, 100 * UNIT);
    send_cell(S_MAX, -80 * UNIT, 20 * UNIT, 0, 100 * UNIT);
    send_cell(5, S_MIN, S_MAX, 5, 6);
    send_cell(6, S_MAX, S_MIN, 5, 6);
    send_cell(0, -1, 1, S_MIN, S_MAX);
    send_cell(S_MIN, S_MIN, S_MAX, S_MIN, S_MAX);
    send_cell(S_MAX, S_MAX, S_MIN, S_MIN, S_MAX);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 300 == 0) begin
        steady = ($urandom_range(0, 2) == 0);
      end
      sel = $urandom_range(0, 9);
      rest = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom) >>> 8;
      peak = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom) >>> 8;
      if (sel == 0) begin
        send_cell($urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        scale = $urandom_range(0, 30);
        d = longint'($urandom & ((32'd1 << scale) - 1)) + 1;
        dep = longint'($signed($urandom) >>> 1);
        if (sel == 1) begin
          send_cell($urandom, rest, peak, clamp32(dep), clamp32(dep - d + 1));
        end else begin
          case ($urandom_range(0, 2))
            0: t = dep - (d * longint'($urandom_range(0, 1000))) / 4000;
            1: t = dep + (d * longint'($urandom_range(0, 1000))) / 1000;
            default: t = dep + d + (d * longint'($urandom_range(0, 1000))) / 400;
          endcase
          send_cell(clamp32(t), rest, peak, clamp32(dep), clamp32(dep + d));
        end
      end
    end

    steady = 1'b0;
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
